// File: hdl/par_pkg.sv
`default_nettype none

package par_pkg;

    // Fixed field widths of the stream items and registers.
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 32;
    localparam int CIDX_W     = 12;
    localparam int MODE_W     = 2;
    localparam int OUT_W      = 32;
    localparam int STEP_W     = 36;
    localparam int LIMIT_W    = 7;
    localparam int PHASE_W    = 37;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 36;

    // Input tdata layout, lowest field first, padded to whole bytes.
    localparam int SAMPLE_LSB = 0;
    localparam int CIDX_LSB   = SAMPLE_LSB + SAMPLE_W;
    localparam int CVAL_LSB   = CIDX_LSB + CIDX_W;
    localparam int S_TDATA_W  = ((CVAL_LSB + COEF_W + 7) / 8) * 8;

    localparam int MAX_RESULTS = 64;

    localparam int DEF_TAPS           = 24;
    localparam int DEF_PHASES         = 128;
    localparam int DEF_COEF_FRAC_BITS = 15;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 36'h1_0000_0000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [PHASE_W-1:0] PHASE_ONE   = 37'h1_0000_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 2'd0,
        MODE_COEF  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef struct packed {
        logic push;
        logic coef_we;
        logic clear;
        logic mul;
        logic base;
        logic acc_clr;
        logic issue;
        logic diff;
        logic ser;
        logic sum;
        logic emit;
        logic last;
        logic wrap;
    } t_dp_cmd;

    typedef struct packed {
        logic ph_lt_one;
        logic ph_next_lt_one;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hdl/par_ram.sv
`default_nettype none

module par_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// File: hdl/par_ctrl.sv
`default_nettype none

module par_ctrl
    import par_pkg::*;
#(
    parameter int TAPS = DEF_TAPS
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire  [MODE_W-1:0]      i_mode,
    output logic                   o_ready,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_dp_sts                i_sts,
    output t_dp_cmd                o_cmd
);

    localparam int CW = ($clog2(TAPS + 2) > 4) ? $clog2(TAPS + 2) : 4;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_CHECK = 9'b0_0000_0010,
        S_MUL   = 9'b0_0000_0100,
        S_BASE  = 9'b0_0000_1000,
        S_MAC   = 9'b0_0001_0000,
        S_DIFF  = 9'b0_0010_0000,
        S_SER   = 9'b0_0100_0000,
        S_SUM   = 9'b0_1000_0000,
        S_EMIT  = 9'b1_0000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [LIMIT_W-1:0] r_nout, n_nout;
    logic [LIMIT_W-1:0] r_limit;
    logic [LIMIT_W-1:0] w_lim;
    logic               w_more_now;
    logic               w_more_next;

    // Limits above MAX_RESULTS (64) saturate to it.
    assign w_lim = (r_limit > LIMIT_W'(MAX_RESULTS)) ? LIMIT_W'(MAX_RESULTS) : r_limit;
    assign w_more_now  = i_sts.ph_lt_one && (r_nout < w_lim);
    assign w_more_next = i_sts.ph_next_lt_one && ((r_nout + 1'b1) < w_lim);

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_nout  = r_nout;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (t_mode'(i_mode))
                        MODE_PUSH: begin
                            o_cmd.push = 1'b1;
                            n_nout     = '0;
                            n_state    = S_CHECK;
                        end
                        MODE_COEF:  o_cmd.coef_we = 1'b1;
                        MODE_CLEAR: o_cmd.clear   = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (w_more_now) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.wrap = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_BASE;
            end
            S_BASE: begin
                o_cmd.base    = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_cnt         = '0;
                n_state       = S_MAC;
            end
            S_MAC: begin
                // Reads go out while the count is below TAPS; the count then runs on
                // so that the multiply and accumulate stages drain before S_DIFF.
                o_cmd.issue = (r_cnt < CW'(TAPS));
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CW'(TAPS + 1)) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_cnt      = '0;
                n_state    = S_SER;
            end
            S_SER: begin
                o_cmd.ser = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CW'(FRAC_W - 1)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = !w_more_next;
                    n_nout     = r_nout + 1'b1;
                    n_state    = S_CHECK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_nout  <= '0;
            r_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_nout  <= n_nout;
            if (i_cfg_we && (i_cfg_addr == REG_LIMIT)) begin
                r_limit <= i_cfg_data[LIMIT_W-1:0];
            end
        end
    end

    a_push_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_mode == MODE_PUSH)) |=> (r_state == S_CHECK))
        else $error("push beat did not start a run");

    a_emit_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_nout < w_lim))
        else $error("more results than the per-sample limit");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_CHECK) ##1 (r_state == S_IDLE))
        else $error("run continued after the beat marked last");

endmodule

`default_nettype wire

// File: hdl/par_dp.sv
`default_nettype none

module par_dp
    import par_pkg::*;
#(
    parameter int TAPS           = DEF_TAPS,
    parameter int PHASES         = DEF_PHASES,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  [S_TDATA_W-1:0]   i_tdata,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  wire                    i_m_ready,
    output logic                   o_m_valid,
    output logic [OUT_W-1:0]       o_m_data,
    output logic                   o_m_last
);

    localparam int COEF_WORDS = (PHASES + 1) * TAPS;
    localparam int AW         = $clog2(COEF_WORDS);
    localparam int CIW        = (AW > CIDX_W) ? AW : CIDX_W;
    localparam int TW         = $clog2(TAPS);
    localparam int RW         = $clog2(PHASES);
    localparam int MW         = 32 + $clog2(PHASES + 1);
    localparam int PRODW      = COEF_W + SAMPLE_W;
    localparam int ACC_W      = PRODW + $clog2(TAPS);
    localparam int DW         = ACC_W + 1;
    localparam int PW         = DW + FRAC_W;
    localparam int VW         = ACC_W + 2;
    localparam logic [VW-1:0] HALF = VW'(1) << (COEF_FRAC_BITS - 1);

    logic signed [SAMPLE_W-1:0] r_hist [TAPS];
    logic                       r_primed;
    logic [PHASE_W-1:0]         r_phase;
    logic [STEP_W-1:0]          r_step;
    logic [RW-1:0]              r_row;
    logic [FRAC_W-1:0]          r_frac;
    logic [AW-1:0]              r_base;
    logic [TW-1:0]              r_tap;
    logic signed [SAMPLE_W-1:0] r_hs1;
    logic                       r_v1, r_v2;
    logic signed [PRODW-1:0]    r_pa, r_pb;
    logic signed [ACC_W-1:0]    r_acc_a, r_acc_b;
    logic signed [DW-1:0]       r_d;
    logic signed [PW-1:0]       r_prod;
    logic signed [VW-1:0]       r_v;
    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out_data;
    logic                       r_out_last;

    logic signed [SAMPLE_W-1:0] w_sample;
    logic [CIW-1:0]             w_cidx;
    logic                       w_we;
    logic [PHASE_W-1:0]         w_ph_next;
    logic [MW-1:0]              w_m;
    logic [AW-1:0]              w_ra, w_rb;
    logic [COEF_W-1:0]          w_rd_a, w_rd_b;
    logic signed [VW-1:0]       w_vr;
    logic signed [VW+OUT_W-1:0] w_vx;

    assign w_sample  = $signed(i_tdata[SAMPLE_LSB +: SAMPLE_W]);
    assign w_cidx    = CIW'(i_tdata[CIDX_LSB +: CIDX_W]);
    // Writes past the end of the table are dropped.
    assign w_we      = i_cmd.coef_we && (w_cidx < CIW'(COEF_WORDS));
    assign w_ph_next = r_phase + PHASE_W'(r_step);
    assign w_m       = MW'(r_phase[31:0]) * MW'(PHASES);
    assign w_ra      = r_base + AW'(r_tap);
    assign w_rb      = r_base + AW'(TAPS) + AW'(r_tap);

    assign w_vr = r_v + $signed(HALF);
    assign w_vx = (VW + OUT_W)'(w_vr);

    assign o_sts.ph_lt_one      = (r_phase[PHASE_W-1:32] == '0);
    assign o_sts.ph_next_lt_one = (w_ph_next[PHASE_W-1:32] == '0);
    assign o_sts.out_free       = !r_out_valid || i_m_ready;

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_last  = r_out_last;

    par_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_WORDS)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_cidx[AW-1:0]),
        .i_wdata   (i_tdata[CVAL_LSB +: COEF_W]),
        .i_raddr_a (w_ra),
        .i_raddr_b (w_rb),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // Tap history, phase, phase step and primed flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_hist[i] <= '0;
            end
            r_primed <= 1'b0;
            r_phase  <= '0;
            r_step   <= STEP_RESET;
        end else begin
            if (i_cfg_we && (i_cfg_addr == REG_STEP)) begin
                r_step <= i_cfg_data[STEP_W-1:0];
            end
            if (i_cmd.clear) begin
                for (int i = 0; i < TAPS; i++) begin
                    r_hist[i] <= '0;
                end
                r_primed <= 1'b0;
                r_phase  <= '0;
            end else begin
                if (i_cmd.push) begin
                    // The first sample after reset or a clear fills every tap.
                    for (int i = 0; i < TAPS - 1; i++) begin
                        r_hist[i] <= r_primed ? r_hist[i+1] : w_sample;
                    end
                    r_hist[TAPS-1] <= w_sample;
                    r_primed       <= 1'b1;
                end
                if (i_cmd.emit) begin
                    r_phase <= w_ph_next;
                end else if (i_cmd.wrap && !o_sts.ph_lt_one) begin
                    r_phase <= r_phase - PHASE_ONE;
                end
            end
        end
    end

    // Row, fraction, the dual multiply-accumulate pipeline, the interpolation and the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_row  <= w_m[32 +: RW];
            r_frac <= w_m[31:16];
        end else if (i_cmd.ser) begin
            r_frac <= r_frac << 1;
        end
        if (i_cmd.base) begin
            r_base <= AW'(r_row) * AW'(TAPS);
        end
        if (i_cmd.acc_clr) begin
            r_tap <= '0;
        end else if (i_cmd.issue) begin
            r_tap <= r_tap + 1'b1;
        end
        r_hs1 <= r_hist[r_tap];
        r_pa  <= $signed(w_rd_a) * r_hs1;
        r_pb  <= $signed(w_rd_b) * r_hs1;
        if (i_cmd.acc_clr) begin
            r_acc_a <= '0;
            r_acc_b <= '0;
        end else if (r_v2) begin
            r_acc_a <= r_acc_a + ACC_W'(r_pa);
            r_acc_b <= r_acc_b + ACC_W'(r_pb);
        end
        // Difference of the two rows times the fraction, one fraction bit
        // per cycle from the top down.
        if (i_cmd.diff) begin
            r_d    <= DW'(r_acc_b) - DW'(r_acc_a);
            r_prod <= '0;
        end else if (i_cmd.ser) begin
            r_prod <= (r_prod <<< 1) + (r_frac[FRAC_W-1] ? PW'(r_d) : PW'(0));
        end
        if (i_cmd.sum) begin
            r_v <= VW'(r_acc_a) + VW'($signed(r_prod[PW-1:FRAC_W]));
        end
        if (i_cmd.emit) begin
            r_out_data <= w_vx[COEF_FRAC_BITS +: OUT_W];
            r_out_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_m_ready))
        else $error("result loaded over a beat not yet taken");

    a_push_primes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && !i_cmd.clear) |=> r_primed)
        else $error("history not primed after a push");

endmodule

`default_nettype wire

// File: hdl/polyphase_audio_resampler_unit.sv
// Polyphase sample rate converter with linear interpolation between
// coefficient rows.
// Input stream: s_axis_tuser selects the kind of beat (0 push sample,
// 1 write coefficient, 2 clear history and phase, 3 ignored); s_axis_tdata
// carries sample, coefficient index and coefficient word. Coefficients must
// be loaded before samples are pushed; a clear keeps them.
// Output stream: one beat per emitted sample; m_axis_tlast marks the final
// output caused by a pushed sample. A push may produce no output.
// Configuration: a write with i_cfg_we sets phase_step (index 0) or the
// outputs-per-sample limit (index 1); write only while the block is idle.
// Processing: one input beat is processed at a time. For each output the
// two coefficient rows are read and multiply-accumulated one tap per cycle,
// then the row difference is scaled by the fraction one bit per cycle.
// A push runs its outputs one after another; coefficient writes and clears
// are done in the idle state. s_axis_tready is high only between samples.
// The finished output sits in a register, so a stalled receiver only holds
// the next output in progress; the next input is taken after the last one.
// Reset is synchronous and needs no clearing pass.
`default_nettype none

module polyphase_audio_resampler_unit
    import par_pkg::*;
#(
    parameter int TAPS           = DEF_TAPS,
    parameter int PHASES         = DEF_PHASES,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [S_TDATA_W-1:0]   s_axis_tdata,  // sample, coef_index, coef_value
    input  wire  [MODE_W-1:0]      s_axis_tuser,  // mode
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,  // out_sample
    output logic                   m_axis_tlast,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    par_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .o_ready    (s_axis_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    par_dp #(
        .TAPS           (TAPS),
        .PHASES         (PHASES),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tdata    (s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_m_data   (m_axis_tdata),
        .o_m_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire
